// File: src/sihf_pkg.sv
// ----------------------------------------------------------------------------
// sihf_pkg
// Shared widths, register indexes and fixed-point helpers for the
// height-field smoother.
// ----------------------------------------------------------------------------
package sihf_pkg;

   localparam int NUM_COMP       = 4;
   localparam int LANES          = 4;
   localparam int MAX_ROW_LENGTH = 1024;

   localparam int COL_W   = (MAX_ROW_LENGTH > 2) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int LEN_W   = $clog2(MAX_ROW_LENGTH + 1);
   localparam int CFG_LEN_W = 11;
   localparam int CMP_W   = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

   localparam int NOISE_W = 16;
   localparam int COEF_W  = 16;
   localparam int VAL_W   = 24;           // Q1.23 filter values
   localparam int DIFF_W  = VAL_W + 1;
   localparam int PROD_W  = DIFF_W + COEF_W + 1;
   localparam int DELTA_W = PROD_W - 16;
   localparam int AMP_W   = VAL_W + COEF_W;
   localparam int ACC_W   = AMP_W + 2;
   localparam int SH_W    = ACC_W - 15;
   localparam int WORD_W  = 32;
   localparam int CSR_W   = 64;
   localparam int LINE_W  = VAL_W * LANES;

   typedef enum logic [2:0] {
      CSR_ALPHA_X      = 3'd0,
      CSR_ALPHA_Y      = 3'd1,
      CSR_AMPLITUDE    = 3'd2,
      CSR_ROW_LENGTH   = 3'd3,
      CSR_TILT_X_START = 3'd4,
      CSR_TILT_X_STEP  = 3'd5,
      CSR_TILT_Y_START = 3'd6,
      CSR_TILT_Y_STEP  = 3'd7
   } csr_index_type;

   // signed difference times unsigned Q0.16 coefficient
   function automatic logic signed [PROD_W-1:0] mul_coef(
      input logic signed [DIFF_W-1:0] d,
      input logic [COEF_W-1:0]        a
   );
      logic signed [COEF_W:0] a_s;
      a_s = signed'({1'b0, a});
      return PROD_W'(d) * PROD_W'(a_s);
   endfunction

   // add half, floor shift by 16
   function automatic logic signed [DELTA_W-1:0] round_q16(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(32768);
      return DELTA_W'(t >>> 16);
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_val(
      input logic signed [VAL_W+2:0] v
   );
      logic [3:0] top;
      top = v[VAL_W+2:VAL_W-1];
      if (top == 4'b0000 || top == 4'b1111) begin
         return v[VAL_W-1:0];
      end
      return v[VAL_W+2] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(
      input logic signed [WORD_W+1:0] v
   );
      logic [2:0] top;
      top = v[WORD_W+1:WORD_W-1];
      if (top == 3'b000 || top == 3'b111) begin
         return v[WORD_W-1:0];
      end
      return v[WORD_W+1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

endpackage

// File: src/sihf_ram.sv
// ----------------------------------------------------------------------------
// sihf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sihf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/separable_iir_height_field_smoother.sv
// ----------------------------------------------------------------------------
// separable_iir_height_field_smoother
// Row and column first-order smoothing of four noise components per pixel,
// amplitude-weighted sum plus x/y tilt ramps, one height word per pixel.
// ----------------------------------------------------------------------------
// One pixel word is in flight at a time, going from acceptance to the result
// register through a line-buffer read at acceptance, then row multiply, row
// update, column multiply, column update with line-buffer write-back,
// amplitude multiply, sum and tilt add. The sequencer around that single
// read-modify-write of the line buffer stalls new words until it returns
// to idle; a waiting result does not hold off the next accepted word until
// the sequencer needs the output register again. The line buffer holds one
// 96-bit entry per column and needs no clearing after reset.
module separable_iir_height_field_smoother (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sihf_pkg::NOISE_W-1:0]    req_noise_a,
   input  logic signed [sihf_pkg::NOISE_W-1:0]    req_noise_b,
   input  logic signed [sihf_pkg::NOISE_W-1:0]    req_noise_c,
   input  logic signed [sihf_pkg::NOISE_W-1:0]    req_noise_d,
   input  logic                                   req_frame_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sihf_pkg::WORD_W-1:0]     rsp_height,
   output logic                                   rsp_row_end,
   input  logic                                   csr_wr_en,
   input  logic [2:0]                             csr_index,
   input  logic [sihf_pkg::CSR_W-1:0]             csr_wr_data
);
   import sihf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_ROW_MUL = 8'b0000_0010,
      ST_ROW_ADD = 8'b0000_0100,
      ST_COL_MUL = 8'b0000_1000,
      ST_COL_ADD = 8'b0001_0000,
      ST_AMP_MUL = 8'b0010_0000,
      ST_SUM     = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } state_type;

   // configuration
   logic [CSR_W-1:0]        alpha_x_ff, alpha_y_ff, amp_ff;
   logic [CFG_LEN_W-1:0]    row_length_ff;
   logic signed [WORD_W-1:0] tx_start_ff, tx_step_ff, ty_start_ff, ty_step_ff;

   // persistent state
   state_type               state_ff, state_in;
   logic [COL_W-1:0]        col_cnt_ff;
   logic                    first_row_ff;
   logic signed [WORD_W-1:0] tx_run_ff, ty_run_ff;
   logic signed [VAL_W-1:0] rowv_ff [LANES];

   // per-word working registers
   logic signed [VAL_W-1:0]  x_ff [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [VAL_W-1:0]  c_ff [LANES];
   logic signed [AMP_W-1:0]  ampp_ff [LANES];
   logic signed [SH_W-1:0]   sh_ff;
   logic [COL_W-1:0]         col_ff;
   logic                     col_zero_ff, first_ff, last_ff;
   logic signed [WORD_W-1:0] tx_ff, ty_ff;

   // result register
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_height_ff;
   logic                     rsp_row_end_ff;

   // line buffer
   logic [LINE_W-1:0]       ram_rd_data, ram_wr_data;
   logic                    accept;

   // acceptance-time control
   logic [CMP_W-1:0]        len_eff;
   logic [COL_W-1:0]        col_raw, col_sel;
   logic                    first_sel, last_sel;
   logic signed [WORD_W-1:0] tx_cur, ty_cur;
   logic signed [VAL_W-1:0] x_in [LANES];

   // datapath
   logic signed [VAL_W-1:0] row_r [LANES];
   logic signed [VAL_W-1:0] col_c [LANES];
   logic signed [VAL_W-1:0] prev_v [LANES];
   logic signed [ACC_W-1:0] acc;
   logic                    out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign x_in[0] = {req_noise_a, 8'h00};
   assign x_in[1] = {req_noise_b, 8'h00};
   assign x_in[2] = {req_noise_c, 8'h00};
   assign x_in[3] = {req_noise_d, 8'h00};

   always_comb begin
      priority if (row_length_ff == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(row_length_ff) > CMP_W'(MAX_ROW_LENGTH)) begin
         len_eff = CMP_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = CMP_W'(row_length_ff);
      end
      col_raw   = req_frame_start ? '0 : col_cnt_ff;
      first_sel = req_frame_start || first_row_ff;
      // a shrunk row length clips the column to the last one
      col_sel   = (CMP_W'(col_raw) >= len_eff) ? COL_W'(len_eff - CMP_W'(1)) : col_raw;
      last_sel  = (CMP_W'(col_sel) + CMP_W'(1)) >= len_eff;
      tx_cur    = (col_sel == '0) ? tx_start_ff : tx_run_ff;
      ty_cur    = ((col_sel == '0) && first_sel) ? ty_start_ff : ty_run_ff;
   end

   always_comb begin
      acc = ACC_W'(16384);
      for (int k = 0; k < LANES; k++) begin
         prev_v[k] = ram_rd_data[VAL_W*k +: VAL_W];
         if (col_zero_ff) begin
            row_r[k] = x_ff[k];
         end else begin
            row_r[k] = sat_val((VAL_W+3)'(rowv_ff[k]) + (VAL_W+3)'(round_q16(prod_ff[k])));
         end
         if (first_ff) begin
            col_c[k] = rowv_ff[k];
         end else begin
            col_c[k] = sat_val((VAL_W+3)'(prev_v[k]) + (VAL_W+3)'(round_q16(prod_ff[k])));
         end
         if (k >= NUM_COMP) begin
            col_c[k] = '0;
         end
         ram_wr_data[VAL_W*k +: VAL_W] = col_c[k];
         acc = acc + ACC_W'(ampp_ff[k]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_ROW_MUL;
         ST_ROW_MUL: state_in = ST_ROW_ADD;
         ST_ROW_ADD: state_in = ST_COL_MUL;
         ST_COL_MUL: state_in = ST_COL_ADD;
         ST_COL_ADD: state_in = ST_AMP_MUL;
         ST_AMP_MUL: state_in = ST_SUM;
         ST_SUM:     state_in = ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_cnt_ff    <= '0;
         first_row_ff  <= 1'b1;
         tx_run_ff     <= '0;
         ty_run_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         alpha_x_ff    <= '0;
         alpha_y_ff    <= '0;
         amp_ff        <= '0;
         row_length_ff <= CFG_LEN_W'(1024);
         tx_start_ff   <= '0;
         tx_step_ff    <= '0;
         ty_start_ff   <= '0;
         ty_step_ff    <= '0;
         for (int k = 0; k < LANES; k++) begin
            rowv_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_ALPHA_X:      alpha_x_ff    <= csr_wr_data;
               CSR_ALPHA_Y:      alpha_y_ff    <= csr_wr_data;
               CSR_AMPLITUDE:    amp_ff        <= csr_wr_data;
               CSR_ROW_LENGTH:   row_length_ff <= csr_wr_data[CFG_LEN_W-1:0];
               CSR_TILT_X_START: tx_start_ff   <= csr_wr_data[WORD_W-1:0];
               CSR_TILT_X_STEP:  tx_step_ff    <= csr_wr_data[WORD_W-1:0];
               CSR_TILT_Y_START: ty_start_ff   <= csr_wr_data[WORD_W-1:0];
               CSR_TILT_Y_STEP:  ty_step_ff    <= csr_wr_data[WORD_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            if (last_sel) begin
               col_cnt_ff   <= '0;
               first_row_ff <= 1'b0;
               tx_run_ff    <= tx_cur;
               ty_run_ff    <= sat_word((WORD_W+2)'(ty_cur) + (WORD_W+2)'(ty_step_ff));
            end else begin
               col_cnt_ff   <= col_sel + COL_W'(1);
               first_row_ff <= first_sel;
               tx_run_ff    <= sat_word((WORD_W+2)'(tx_cur) + (WORD_W+2)'(tx_step_ff));
               ty_run_ff    <= ty_cur;
            end
         end
         if (state_ff == ST_ROW_ADD) begin
            for (int k = 0; k < LANES; k++) begin
               if (k < NUM_COMP) begin
                  rowv_ff[k] <= row_r[k];
               end
            end
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff      <= col_sel;
         col_zero_ff <= (col_sel == '0);
         first_ff    <= first_sel;
         last_ff     <= last_sel;
         tx_ff       <= tx_cur;
         ty_ff       <= ty_cur;
         for (int k = 0; k < LANES; k++) begin
            x_ff[k] <= x_in[k];
         end
      end
      for (int k = 0; k < LANES; k++) begin
         if (state_ff == ST_ROW_MUL) begin
            prod_ff[k] <= mul_coef(DIFF_W'(x_ff[k]) - DIFF_W'(rowv_ff[k]),
                                   alpha_x_ff[COEF_W*k +: COEF_W]);
         end
         if (state_ff == ST_COL_MUL) begin
            prod_ff[k] <= mul_coef(DIFF_W'(rowv_ff[k]) - DIFF_W'(prev_v[k]),
                                   alpha_y_ff[COEF_W*k +: COEF_W]);
         end
         if (state_ff == ST_COL_ADD) begin
            c_ff[k] <= col_c[k];
         end
         if (state_ff == ST_AMP_MUL) begin
            ampp_ff[k] <= AMP_W'(c_ff[k]) *
                          AMP_W'(signed'({1'b0, amp_ff[COEF_W*k +: COEF_W]}));
         end
      end
      if (state_ff == ST_SUM) begin
         sh_ff <= SH_W'(acc >>> 15);
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_height_ff  <= sat_word((WORD_W+2)'(sh_ff) + (WORD_W+2)'(tx_ff)
                                    + (WORD_W+2)'(ty_ff));
         rsp_row_end_ff <= last_ff;
      end
   end

   sihf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_ROW_LENGTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (state_ff == ST_COL_ADD),
      .wr_addr (col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_sel),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_height  = rsp_height_ff;
   assign rsp_row_end = rsp_row_end_ff;

   // a result only appears from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result word raised outside output step");

   // an accepted word always starts the row multiply
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ROW_MUL)
      else $error("accepted word did not start sequencer");

   // the column counter wraps at the end of a row
   a_row_end_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && last_ff) |-> col_cnt_ff == '0)
      else $error("column counter not cleared at row end");

endmodule
